// File: rtl/rofr_pkg.sv
package rofr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_CHAR = 2'd2;

    localparam logic [8:0] CANVAS_WIDTH_RST  = 9'd256;
    localparam logic [8:0] CANVAS_HEIGHT_RST = 9'd256;
    localparam logic [7:0] BACKGROUND_RST    = 8'd32;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_RECT = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [7:0] KIND_OUTLINE = 8'h72;  // 'r'
    localparam logic [7:0] KIND_FILLED  = 8'h52;  // 'R'

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         rect_kind;
        logic signed [19:0] left_pos;
        logic signed [19:0] top_pos;
        logic signed [19:0] span_x;
        logic signed [19:0] span_y;
        logic [7:0]         paint_char;
        logic [7:0]         read_row;
        logic [7:0]         read_col;
    } t_cmd;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [1:0] status;
    } t_result;

    // outcome of one coordinate tested against one interval
    typedef struct packed {
        logic hit;
        logic near;
    } t_cover;

endpackage

// File: rtl/rectangle_outline_fill_raster_core.sv
// Rectangle rasterizer on a byte canvas. Raise start with a command while busy is low;
// exactly one result comes back on o_result, marked by o_done for a single cycle, and the
// receiver cannot stall it, so capture it when o_done is high. Clear and draw walk the
// canvas row by row through one shared interval-compare unit: a row state tests the row
// against the rectangle's vertical span, then a column state tests each pixel in turn. A
// read goes through the registered canvas memory port; a rejected draw, a read out of
// range, an empty canvas or the unused opcode answers on the cycle after it is taken.
// Canvas contents are undefined after reset until a clear has run.
module rectangle_outline_fill_raster_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rofr_pkg::t_cmd                      i_cmd,
    output logic                                o_done,
    output rofr_pkg::t_result                   o_result,
    input  logic                                i_cfg_we,
    input  logic [rofr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rofr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import rofr_pkg::*;

    localparam int CIDX = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RIDX = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW   = CIDX + RIDX;
    localparam int LW   = 11;
    localparam int XIDX = (CIDX > RIDX) ? CIDX : RIDX;
    localparam int DW   = ((XIDX + FRAC_BITS > 21) ? XIDX + FRAC_BITS : 21) + 2;

    localparam logic [LW-1:0] MAX_W = LW'(MAX_WIDTH);
    localparam logic [LW-1:0] MAX_H = LW'(MAX_HEIGHT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROW  = 2'd1;
    localparam logic [1:0] S_COL  = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    // control
    logic [1:0]      r_state, n_state;
    logic            r_error, n_error;
    logic            r_done,  n_done;
    logic [8:0]      r_cfg_w, r_cfg_h;
    logic [7:0]      r_bg;

    // payload
    logic [RIDX-1:0]      r_row, n_row;
    logic [CIDX-1:0]      r_col, n_col;
    logic signed [DW-1:0] r_x0, r_x1, r_y0, r_y1;
    logic signed [DW-1:0] n_x0, n_x1, n_y0, n_y1;
    logic                 r_clear, n_clear;
    logic                 r_outline, n_outline;
    logic [7:0]           r_paint, n_paint;
    logic                 r_row_in, n_row_in;
    logic                 r_row_near, n_row_near;
    t_result              r_result, n_result;

    logic [LW-1:0]        w_used, h_used;
    logic                 accept, empty, bad_rect, rd_out;
    logic signed [DW-1:0] cu_pos, cu_lo, cu_hi;
    t_cover               cu;
    logic                 wr_en;
    logic [7:0]           rd_data;

    assign w_used = ({2'b00, r_cfg_w} > MAX_W) ? MAX_W : {2'b00, r_cfg_w};
    assign h_used = ({2'b00, r_cfg_h} > MAX_H) ? MAX_H : {2'b00, r_cfg_h};
    assign empty  = (w_used == '0) || (h_used == '0);

    assign accept   = start && !busy;
    assign bad_rect = (i_cmd.span_x <= 20'sd0) || (i_cmd.span_y <= 20'sd0) ||
                      ((i_cmd.rect_kind != KIND_OUTLINE) && (i_cmd.rect_kind != KIND_FILLED));
    assign rd_out   = ({3'b000, i_cmd.read_row} >= h_used) ||
                      ({3'b000, i_cmd.read_col} >= w_used);

    // the compare unit tests the row in S_ROW and each column in S_COL
    always_comb begin
        if (r_state == S_ROW) begin
            cu_pos = DW'(r_row) << FRAC_BITS;
            cu_lo  = r_y0;
            cu_hi  = r_y1;
        end else begin
            cu_pos = DW'(r_col) << FRAC_BITS;
            cu_lo  = r_x0;
            cu_hi  = r_x1;
        end
    end

    rofr_cover #(
        .DW        (DW),
        .FRAC_BITS (FRAC_BITS)
    ) u_cover (
        .i_pos   (cu_pos),
        .i_lo    (cu_lo),
        .i_hi    (cu_hi),
        .o_cover (cu)
    );

    assign wr_en = (r_state == S_COL) &&
                   (r_clear || (r_row_in && cu.hit &&
                                (!r_outline || r_row_near || cu.near)));

    rofr_canvas #(
        .AW (AW)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr ({r_row, r_col}),
        .i_wdata (r_paint),
        .i_raddr ({r_row, r_col}),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_error    = r_error;
        n_done     = 1'b0;
        n_row      = r_row;
        n_col      = r_col;
        n_x0       = r_x0;
        n_x1       = r_x1;
        n_y0       = r_y0;
        n_y1       = r_y1;
        n_clear    = r_clear;
        n_outline  = r_outline;
        n_paint    = r_paint;
        n_row_in   = r_row_in;
        n_row_near = r_row_near;
        n_result   = r_result;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_result = '{pixel_value: 8'd0, status: ST_OK};
                    n_row    = '0;
                    n_col    = '0;
                    unique case (i_cmd.opcode)
                        OP_CLEAR: begin
                            n_error = 1'b0;
                            n_clear = 1'b1;
                            n_paint = r_bg;
                            if (empty) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_ROW;
                            end
                        end
                        OP_DRAW: begin
                            n_clear   = 1'b0;
                            n_paint   = i_cmd.paint_char;
                            n_outline = (i_cmd.rect_kind == KIND_OUTLINE);
                            n_x0      = DW'(i_cmd.left_pos);
                            n_y0      = DW'(i_cmd.top_pos);
                            n_x1      = DW'(i_cmd.left_pos) + DW'(i_cmd.span_x);
                            n_y1      = DW'(i_cmd.top_pos) + DW'(i_cmd.span_y);
                            if (r_error) begin
                                n_result.status = ST_REJECTED;
                                n_done          = 1'b1;
                            end else if (bad_rect) begin
                                n_error         = 1'b1;
                                n_result.status = ST_BAD_RECT;
                                n_done          = 1'b1;
                            end else if (empty) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_ROW;
                            end
                        end
                        OP_READ: begin
                            if (rd_out) begin
                                n_result.status = ST_RANGE;
                                n_done          = 1'b1;
                            end else begin
                                n_row   = RIDX'(i_cmd.read_row);
                                n_col   = CIDX'(i_cmd.read_col);
                                n_state = S_READ;
                            end
                        end
                        OP_NOP: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_ROW: begin
                n_row_in   = cu.hit;
                n_row_near = cu.near;
                n_col      = '0;
                n_state    = S_COL;
            end
            S_COL: begin
                if (LW'(r_col) == w_used - LW'(1)) begin
                    if (LW'(r_row) == h_used - LW'(1)) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + RIDX'(1);
                        n_state = S_ROW;
                    end
                end else begin
                    n_col = r_col + CIDX'(1);
                end
            end
            S_READ: begin
                // while r_clear is set the read is launched and the flag dropped; then the registered data is taken
                if (r_done == 1'b0 && r_clear == 1'b1) begin
                    n_clear = 1'b0;
                end else begin
                    n_result.pixel_value = rd_data;
                    n_done               = 1'b1;
                    n_state              = S_IDLE;
                end
            end
        endcase

        // mark the read so that S_READ waits for the registered memory output before taking the data
        if (r_state == S_IDLE && accept && i_cmd.opcode == OP_READ) begin
            n_clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_error <= 1'b0;
            r_done  <= 1'b0;
            r_cfg_w <= CANVAS_WIDTH_RST;
            r_cfg_h <= CANVAS_HEIGHT_RST;
            r_bg    <= BACKGROUND_RST;
        end else begin
            r_state <= n_state;
            r_error <= n_error;
            r_done  <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_CANVAS_WIDTH:    r_cfg_w <= i_cfg_wdata;
                    REG_CANVAS_HEIGHT:   r_cfg_h <= i_cfg_wdata;
                    REG_BACKGROUND_CHAR: r_bg    <= i_cfg_wdata[7:0];
                    default: begin
                        // unassigned index: drop the write
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_x0       <= n_x0;
        r_x1       <= n_x1;
        r_y0       <= n_y0;
        r_y1       <= n_y1;
        r_clear    <= n_clear;
        r_outline  <= n_outline;
        r_paint    <= n_paint;
        r_row_in   <= n_row_in;
        r_row_near <= n_row_near;
        r_result   <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: rtl/rofr_cover.sv
module rofr_cover #(
    parameter int DW        = 28,
    parameter int FRAC_BITS = 8
) (
    input  logic signed [DW-1:0] i_pos,
    input  logic signed [DW-1:0] i_lo,
    input  logic signed [DW-1:0] i_hi,
    output rofr_pkg::t_cover     o_cover
);
    import rofr_pkg::*;

    localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    logic signed [DW-1:0] from_lo;
    logic signed [DW-1:0] to_hi;

    assign from_lo = i_pos - i_lo;
    assign to_hi   = i_hi - i_pos;

    assign o_cover.hit  = (from_lo >= 0) && (to_hi >= 0);
    assign o_cover.near = (from_lo < ONE) || (to_hi < ONE);

endmodule

// File: rtl/rofr_canvas.sv
module rofr_canvas #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] mem [0:(1<<AW)-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sim/raster_result_checker.sv
module raster_result_checker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  rofr_pkg::t_cmd                      i_cmd,
    input  logic                                i_done,
    input  rofr_pkg::t_result                   i_result,
    input  logic                                i_cfg_we,
    input  logic [rofr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rofr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rofr_pkg::*;

    localparam longint ONE = longint'(1) << FRAC_BITS;

    logic [7:0] canvas_bytes [MAX_WIDTH*MAX_HEIGHT];
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [7:0] background_reg;
    logic       error_latched;
    t_result    awaited_results [$];

    function automatic int unsigned used_size(logic [8:0] v, int unsigned limit);
        return (v > limit) ? limit : v;
    endfunction

    // Apply one command to the canvas copy and return the result it must produce.
    function automatic t_result raster_step(t_cmd c);
        int unsigned w;
        int unsigned h;
        int          r;
        int          col;
        longint      x0, y0, x1, y1, px, py;
        logic        covered;
        logic        near_edge;
        t_result     res;
        w   = used_size(width_reg, MAX_WIDTH);
        h   = used_size(height_reg, MAX_HEIGHT);
        res = '0;
        case (c.opcode)
            OP_CLEAR: begin
                for (r = 0; r < h; r++)
                    for (col = 0; col < w; col++)
                        canvas_bytes[r*MAX_WIDTH + col] = background_reg;
                error_latched = 1'b0;
            end
            OP_DRAW: begin
                if (error_latched) begin
                    res.status = ST_REJECTED;
                end else if ($signed(c.span_x) <= 0 || $signed(c.span_y) <= 0 ||
                             (c.rect_kind != KIND_OUTLINE && c.rect_kind != KIND_FILLED)) begin
                    error_latched = 1'b1;
                    res.status    = ST_BAD_RECT;
                end else begin
                    x0 = $signed(c.left_pos);
                    y0 = $signed(c.top_pos);
                    x1 = x0 + $signed(c.span_x);
                    y1 = y0 + $signed(c.span_y);
                    for (r = 0; r < h; r++) begin
                        for (col = 0; col < w; col++) begin
                            px = longint'(col) * ONE;
                            py = longint'(r) * ONE;
                            covered   = !(px < x0 || x1 < px || py < y0 || y1 < py);
                            near_edge = (px - x0 < ONE) || (x1 - px < ONE) ||
                                        (py - y0 < ONE) || (y1 - py < ONE);
                            if (covered && (c.rect_kind == KIND_FILLED || near_edge))
                                canvas_bytes[r*MAX_WIDTH + col] = c.paint_char;
                        end
                    end
                end
            end
            OP_READ: begin
                if (c.read_row >= h || c.read_col >= w)
                    res.status = ST_RANGE;
                else
                    res.pixel_value = canvas_bytes[c.read_row*MAX_WIDTH + c.read_col];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            width_reg      = CANVAS_WIDTH_RST;
            height_reg     = CANVAS_HEIGHT_RST;
            background_reg = BACKGROUND_RST;
            error_latched  = 1'b0;
            o_fail_count   = 0;
            awaited_results.delete();
        end else begin
            if (i_done) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with none awaited: pixel_value %h status %0d",
                             $time, i_result.pixel_value, i_result.status);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_result.pixel_value !== want.pixel_value) begin
                        $display("%0t: pixel_value expected %h, got %h",
                                 $time, want.pixel_value, i_result.pixel_value);
                        o_fail_count++;
                    end
                    if (i_result.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_result.status);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CANVAS_WIDTH:    width_reg      = i_cfg_wdata;
                    REG_CANVAS_HEIGHT:   height_reg     = i_cfg_wdata;
                    REG_BACKGROUND_CHAR: background_reg = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                awaited_results.push_back(raster_step(i_cmd));
        end
        o_pending = awaited_results.size();
    end

endmodule

// File: sim/rectangle_outline_fill_raster_core_tb.sv
module rectangle_outline_fill_raster_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rofr_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int Q_ONE          = 256;    // 1.0 in Q12.8
    localparam int ITEMS_PER_SET  = 13;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    t_cmd                  cmd;
    logic                  done;
    t_result               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    pending;
    int                    quiet_cycles = 0;
    int                    sender_idle_pct;

    always #1 clk = ~clk;

    rectangle_outline_fill_raster_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    raster_result_checker u_raster_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_done       (done),
        .i_result     (result),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Fill every field with noise, then set the opcode.
    function automatic t_cmd noise_cmd(logic [1:0] op);
        logic [127:0] raw;
        t_cmd         c;
        raw      = {$urandom(), $urandom(), $urandom(), $urandom()};
        c        = raw[$bits(t_cmd)-1:0];
        c.opcode = op;
        return c;
    endfunction

    function automatic t_cmd draw_cmd(logic [7:0] kind, int x, int y, int sx, int sy,
                                      logic [7:0] paint);
        t_cmd c;
        c            = noise_cmd(OP_DRAW);
        c.rect_kind  = kind;
        c.left_pos   = 20'(x);
        c.top_pos    = 20'(y);
        c.span_x     = 20'(sx);
        c.span_y     = 20'(sy);
        c.paint_char = paint;
        return c;
    endfunction

    function automatic t_cmd read_cmd(int row, int col);
        t_cmd c;
        c          = noise_cmd(OP_READ);
        c.read_row = 8'(row);
        c.read_col = 8'(col);
        return c;
    endfunction

    // Mostly well-formed draws and reads around the canvas in use, some noise.
    function automatic t_cmd random_cmd(int w, int h);
        int         pick;
        int         x, y, sx, sy;
        logic [7:0] kind;
        t_cmd       c;
        pick = $urandom_range(99, 0);
        if (pick < 12)
            return noise_cmd(OP_CLEAR);
        if (pick < 60) begin
            c = noise_cmd(OP_DRAW);
            if ($urandom_range(99, 0) < 6)
                return c;
            pick = $urandom_range(99, 0);
            kind = (pick < 48) ? KIND_FILLED : (pick < 96) ? KIND_OUTLINE : c.rect_kind;
            x  = int'($urandom_range((w + 6) * Q_ONE, 0)) - 3 * Q_ONE;
            y  = int'($urandom_range((h + 6) * Q_ONE, 0)) - 3 * Q_ONE;
            sx = ($urandom_range(3, 0) == 0) ? $urandom_range(300, 1)
                                              : $urandom_range((w + 2) * Q_ONE, 1);
            sy = ($urandom_range(3, 0) == 0) ? $urandom_range(300, 1)
                                              : $urandom_range((h + 2) * Q_ONE, 1);
            // snap to whole pixels now and then so edges land exactly on pixels
            if ($urandom_range(2, 0) == 0) begin
                x  &= ~(Q_ONE - 1);
                y  &= ~(Q_ONE - 1);
                sx = (sx / Q_ONE + 1) * Q_ONE;
                sy = (sy / Q_ONE + 1) * Q_ONE;
            end
            return draw_cmd(kind, x, y, sx, sy, c.paint_char);
        end
        if (pick < 93) begin
            if ($urandom_range(9, 0) == 0)
                return noise_cmd(OP_READ);
            return read_cmd($urandom_range((h + 1 > 255) ? 255 : h + 1, 0),
                            $urandom_range((w + 1 > 255) ? 255 : w + 1, 0));
        end
        return noise_cmd(OP_NOP);
    endfunction

    // Hold start low until every awaited result is back and the block is idle.
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0 || busy);
    endtask

    task automatic issue(input t_cmd c);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_canvas(input int w, input int h, input int bg);
        program_reg(REG_CANVAS_WIDTH, 9'(w));
        program_reg(REG_CANVAS_HEIGHT, 9'(h));
        program_reg(REG_BACKGROUND_CHAR, 9'(bg));
    endtask

    initial begin
        int phase;
        int setting;
        int n;
        int w;
        int h;
        rst_n           = 1'b0;
        start           = 1'b0;
        cmd             = '0;
        cfg_we          = 1'b0;
        cfg_idx         = REG_CANVAS_WIDTH;
        cfg_wdata       = '0;
        sender_idle_pct = 13;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full canvas at reset settings: write every pixel once
        issue(noise_cmd(OP_CLEAR));
        issue(read_cmd(255, 255));
        issue(draw_cmd(KIND_FILLED, 250 * Q_ONE + 128, -3 * Q_ONE, 20 * Q_ONE, 4 * Q_ONE, 8'h2a));
        issue(read_cmd(1, 255));

        set_canvas(16, 12, 8'hff);
        issue(noise_cmd(OP_CLEAR));
        issue(draw_cmd(KIND_OUTLINE, 640, 320, 6 * Q_ONE, 1408, 8'h23));
        issue(read_cmd(2, 5));
        issue(draw_cmd(KIND_FILLED, 0, 0, Q_ONE, Q_ONE, 8'h00));
        issue(draw_cmd(KIND_FILLED, -524288, -524288, 524287, 524287, 8'h01));
        issue(draw_cmd(KIND_OUTLINE, 524287, 524287, 524287, 524287, 8'hfe));
        issue(read_cmd(12, 0));
        issue(noise_cmd(OP_NOP));
        // zero width latches the error; the next draw is turned away, reads still work
        issue(draw_cmd(KIND_FILLED, Q_ONE, Q_ONE, 0, Q_ONE, 8'h55));
        issue(draw_cmd(KIND_FILLED, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 8'h55));
        issue(read_cmd(1, 1));
        issue(noise_cmd(OP_CLEAR));
        issue(draw_cmd(8'h78, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 8'haa));
        issue(noise_cmd(OP_CLEAR));
        issue(draw_cmd(KIND_OUTLINE, 0, 0, Q_ONE, -524288, 8'haa));
        issue(noise_cmd(OP_CLEAR));

        // empty canvas
        set_canvas(0, 12, 8'h00);
        issue(noise_cmd(OP_CLEAR));
        issue(draw_cmd(KIND_FILLED, 0, 0, 4 * Q_ONE, 4 * Q_ONE, 8'h11));
        issue(read_cmd(0, 0));

        // width above the maximum saturates
        set_canvas(511, 2, 8'h20);
        issue(draw_cmd(KIND_FILLED, 254 * Q_ONE, 0, Q_ONE, Q_ONE, 8'h77));
        issue(read_cmd(0, 255));
        issue(read_cmd(1, 254));

        for (phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 86 : 0;
            for (setting = 0; setting < 2; setting++) begin
                if (phase == 2 && setting == 0) begin
                    w = 1;
                    h = 256;
                    set_canvas(w, h, 0);
                end else begin
                    if ($urandom_range(3, 0) == 0) begin
                        w = $urandom_range(511, 200);
                        h = $urandom_range(4, 1);
                    end else begin
                        w = $urandom_range(24, 1);
                        h = $urandom_range(16, 1);
                    end
                    set_canvas(w, h, $urandom_range(255, 0));
                end
                if (w > 256)
                    w = 256;
                for (n = 0; n < ITEMS_PER_SET; n++) begin
                    if ($urandom_range(19, 0) == 0)
                        wait_drained();
                    issue(random_cmd(w, h));
                end
            end
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/rofr_pkg.sv
rtl/rofr_cover.sv
rtl/rofr_canvas.sv
rtl/rectangle_outline_fill_raster_core.sv
sim/raster_result_checker.sv
sim/rectangle_outline_fill_raster_core_tb.sv
